@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file of this project.
// Each macro expects the clock and the active-low reset as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/bleasf_pkg.sv @@
// Types, codes and UUID lookup for the advertising service filter.
// No dependencies.
package bleasf_pkg;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2
    } parse_phase_t;

    typedef enum logic [1:0] {
        CLS_OTHER   = 2'd0,
        CLS_LIST    = 2'd1,
        CLS_SVCDATA = 2'd2
    } field_class_t;

    localparam logic [7:0] AD_UUID16_INCOMPLETE = 8'h02;
    localparam logic [7:0] AD_UUID16_COMPLETE   = 8'h03;
    localparam logic [7:0] AD_SVC_DATA_UUID16   = 8'h16;

    localparam logic [15:0] UUID_HEART_RATE  = 16'h180D;
    localparam logic [15:0] UUID_CYCLING_SC  = 16'h1816;
    localparam logic [15:0] UUID_CYCLING_PWR = 16'h1818;

    localparam int unsigned MASK_W = 3;

    // One-hot service bit for a recognized UUID, zero otherwise.
    function automatic logic [MASK_W-1:0] uuid_to_bit(input logic [15:0] uuid);
        logic [MASK_W-1:0] bits;
        bits = '0;
        if (uuid == UUID_HEART_RATE) begin
            bits = 3'b001;
        end else if (uuid == UUID_CYCLING_SC) begin
            bits = 3'b010;
        end else if (uuid == UUID_CYCLING_PWR) begin
            bits = 3'b100;
        end
        return bits;
    endfunction

endpackage

@@ hw/rtl/ble_adv_service_filter.sv @@
// The result is registered: it appears on the output in the cycle after the last byte is transferred.
// Throughput: one payload byte per cycle; the parse state updates in the cycle of transfer.
// The only stall comes from the result register: while a result waits, input is held off.
// Reset: rst_n is asynchronous and active low; it clears the parse state and the result valid.
// Depends on bleasf_pkg.
module ble_adv_service_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bleasf_pkg::MASK_W-1:0] service_mask,
    output logic                          malformed
);
    import bleasf_pkg::*;

    // Running parse state for the packet in flight.
    parse_phase_t      phase_reg, phase_next;
    field_class_t      class_reg, class_next;
    logic [7:0]        left_reg, left_next;
    logic [7:0]        pos_reg, pos_next;
    logic [7:0]        uuid_lo_reg, uuid_lo_next;
    logic [MASK_W-1:0] found_reg, found_next;
    logic              err_reg, err_next;
    logic              term_reg, term_next;

    // Result register; the payload needs no reset.
    logic              res_valid_reg, res_valid_next;
    logic [MASK_W-1:0] res_mask_reg, res_mask_next;
    logic              res_bad_reg, res_bad_next;

    // Values after this byte has been consumed, before the end-of-packet clear.
    parse_phase_t      c_phase;
    field_class_t      c_class;
    logic [7:0]        c_left;
    logic [7:0]        c_pos;
    logic [7:0]        c_uuid_lo;
    logic [MASK_W-1:0] c_found;
    logic              c_err;
    logic              c_term;
    logic              take;
    logic              bad;
    logic              accept;

    // A byte can be taken whenever the result register is empty or being drained.
    assign in_ready = !res_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Consume one byte of the length-type-value walk. Once an error or a zero
    // length byte has been seen, bytes are ignored until the packet ends.
    always_comb
    begin
        c_phase   = phase_reg;
        c_class   = class_reg;
        c_left    = left_reg;
        c_pos     = pos_reg;
        c_uuid_lo = uuid_lo_reg;
        c_found   = found_reg;
        c_err     = err_reg;
        c_term    = term_reg;
        take      = 1'b0;
        if (!err_reg && !term_reg) begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if (data_byte == 8'd0) begin
                        c_term = 1'b1;
                    end else if (data_byte == 8'd1) begin
                        c_err = 1'b1;
                    end else begin
                        c_left  = data_byte - 8'd1;
                        c_phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    priority if (data_byte == AD_UUID16_INCOMPLETE ||
                                 data_byte == AD_UUID16_COMPLETE) begin
                        // A UUID16 list must hold whole UUIDs.
                        if (left_reg[0]) begin
                            c_err = 1'b1;
                        end else begin
                            c_class = CLS_LIST;
                            c_pos   = '0;
                            c_phase = PH_VALUE;
                        end
                    end else if (data_byte == AD_SVC_DATA_UUID16 && left_reg >= 8'd2) begin
                        c_class = CLS_SVCDATA;
                        c_pos   = '0;
                        c_phase = PH_VALUE;
                    end else begin
                        // Unknown types, and service data too short for a UUID, are skipped.
                        c_class = CLS_OTHER;
                        c_pos   = '0;
                        c_phase = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    take = (class_reg == CLS_LIST) ||
                           (class_reg == CLS_SVCDATA && pos_reg < 8'd2);
                    if (take) begin
                        if (!pos_reg[0]) begin
                            c_uuid_lo = data_byte;
                        end else begin
                            c_found = found_reg | uuid_to_bit({data_byte, uuid_lo_reg});
                        end
                    end
                    c_pos  = pos_reg + 8'd1;
                    c_left = left_reg - 8'd1;
                    if (c_left == 8'd0) begin
                        c_phase = PH_LENGTH;
                    end
                end
                default:
                begin
                    c_phase = PH_LENGTH;
                end
            endcase
        end
    end

    // A packet is malformed on an error, or when it ends inside a field.
    assign bad = c_err || (!c_term && c_phase != PH_LENGTH);

    always_comb
    begin
        phase_next     = phase_reg;
        class_next     = class_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        uuid_lo_next   = uuid_lo_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        term_next      = term_reg;
        res_valid_next = res_valid_reg && !out_ready;
        res_mask_next  = res_mask_reg;
        res_bad_next   = res_bad_reg;
        if (accept) begin
            if (last_byte) begin
                // Publish the result and return to the reset state for the next packet.
                res_valid_next = 1'b1;
                res_mask_next  = bad ? '0 : c_found;
                res_bad_next   = bad;
                phase_next     = PH_LENGTH;
                class_next     = CLS_OTHER;
                left_next      = '0;
                pos_next       = '0;
                uuid_lo_next   = '0;
                found_next     = '0;
                err_next       = 1'b0;
                term_next      = 1'b0;
            end else begin
                phase_next   = c_phase;
                class_next   = c_class;
                left_next    = c_left;
                pos_next     = c_pos;
                uuid_lo_next = c_uuid_lo;
                found_next   = c_found;
                err_next     = c_err;
                term_next    = c_term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_LENGTH;
            class_reg     <= CLS_OTHER;
            left_reg      <= '0;
            pos_reg       <= '0;
            uuid_lo_reg   <= '0;
            found_reg     <= '0;
            err_reg       <= 1'b0;
            term_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            class_reg     <= class_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            uuid_lo_reg   <= uuid_lo_next;
            found_reg     <= found_next;
            err_reg       <= err_next;
            term_reg      <= term_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_mask_reg <= res_mask_next;
        res_bad_reg  <= res_bad_next;
    end

    assign out_valid    = res_valid_reg;
    assign service_mask = res_mask_reg;
    assign malformed    = res_bad_reg;

endmodule

@@ hw/rtl/ble_adv_service_filter_checker.sv @@
// Port-level checker for the advertising service filter, with its bind.
// Depends on assert_macros.svh and bleasf_pkg.
`include "assert_macros.svh"

module bleasf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          last_byte,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bleasf_pkg::MASK_W-1:0] service_mask,
    input logic                          malformed
);
    // A stalled result keeps its value until it is transferred.
    `ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(service_mask) && $stable(malformed))

    // A malformed packet never reports services.
    `ASSERT_IMPLIES(a_malformed_mask_zero, clk, rst_n, out_valid && malformed, service_mask == '0)

    // The last byte of a packet yields a result in the next cycle.
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_valid && in_ready && last_byte, out_valid)

    // A result only appears after the last byte of a packet.
    `ASSERT_IMPLIES(a_result_from_last, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && last_byte))

    // Input is held off only while a result waits.
    `ASSERT_IMPLIES(a_stall_only_on_result, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind ble_adv_service_filter bleasf_checker u_bleasf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .service_mask (service_mask),
    .malformed    (malformed)
);
